>>> hw/rtl/smpb_pkg.sv
`timescale 1ns / 1ps
package smpb_pkg;

   localparam int COORD_BITS          = 16;
   localparam int FALLOFF_TABLE_DEPTH = 256;
   localparam int IDX_BITS            = $clog2(FALLOFF_TABLE_DEPTH);
   // magnitude of (coord << 8) - offset
   localparam int MAG_BITS  = (((COORD_BITS + 8) > 20) ? (COORD_BITS + 8) : 20) + 1;
   localparam int EDGE_BITS = 17;
   localparam int NUM_BITS  = EDGE_BITS + IDX_BITS + 1;
   localparam int DIV_BITS  = 18;
   localparam int MASK_BITS = 17;

   localparam logic [MASK_BITS-1:0] MASK_FULL = 17'd65536;
   localparam logic [63:0] Q30_ONE   = 64'd1 << 30;
   localparam logic [63:0] DEPTH_SQ  = 64'(FALLOFF_TABLE_DEPTH) * 64'(FALLOFF_TABLE_DEPTH);

   typedef enum logic [2:0] {
      CSR_SPACING   = 3'd0,
      CSR_WIDTH     = 3'd1,
      CSR_LEAD      = 3'd2,
      CSR_TRAIL     = 3'd3,
      CSR_OFFSET    = 3'd4,
      CSR_OPACITY   = 3'd5,
      CSR_DIRECTION = 3'd6
   } csr_idx_type;

   typedef struct packed {
      logic [15:0] column;
      logic [15:0] row;
      logic [19:0] red_in;
      logic [19:0] green_in;
      logic [19:0] blue_in;
      logic [19:0] alpha_in;
   } req_type;

   typedef struct packed {
      logic [19:0] red_out;
      logic [19:0] green_out;
      logic [19:0] blue_out;
      logic [19:0] alpha_out;
   } rsp_type;

   typedef struct packed {
      logic [19:0] red;
      logic [19:0] green;
      logic [19:0] blue;
      logic [19:0] alpha;
   } pix_type;

   typedef struct packed {
      logic [19:0] stripe_spacing;
      logic [19:0] stripe_width;
      logic [15:0] feather_lead;
      logic [15:0] feather_trail;
      logic [20:0] pattern_offset;
      logic [16:0] effect_opacity;
      logic        stripe_direction;
   } cfg_type;

   typedef logic [MASK_BITS-1:0] rom_type [FALLOFF_TABLE_DEPTH];

   // exp(-f) in q30, f in [0, 1] as q30
   function automatic logic [63:0] exp_neg_q30(input logic [63:0] f);
      longint      sum;
      logic [63:0] term;
      sum  = longint'(Q30_ONE);
      term = Q30_ONE;
      for (int i = 1; i <= 14; i++) begin
         term = ((term * f) >> 30) / 64'(i);
         if ((i % 2) == 1) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      return (sum < 0) ? 64'd0 : 64'(sum);
   endfunction

   function automatic rom_type build_rom();
      rom_type     rom;
      logic [63:0] e1;
      logic [63:0] e;
      logic [63:0] n;
      logic [63:0] v;
      e1 = exp_neg_q30(Q30_ONE);
      for (int k = 0; k < FALLOFF_TABLE_DEPTH; k++) begin
         e = ((64'd25 * 64'(k) * 64'(k)) << 29) / DEPTH_SQ;
         n = e >> 30;
         v = exp_neg_q30(e & (Q30_ONE - 64'd1));
         for (int j = 0; j < 16; j++) begin
            if (64'(j) < n) begin
               v = (v * e1) >> 30;
            end
         end
         rom[k] = MASK_BITS'((v + 64'd8192) >> 14);
      end
      return rom;
   endfunction

   localparam rom_type FALLOFF_ROM = build_rom();

endpackage

>>> hw/rtl/smpb_wrap.sv
`timescale 1ns / 1ps
module smpb_wrap import smpb_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  cfg_type               cfg,
   input  logic                  in_valid,
   input  logic [COORD_BITS-1:0] in_coord,
   input  pix_type               in_pix,
   output logic                  out_valid,
   output pix_type               out_pix,
   output logic [20:0]           out_d2,
   output logic                  out_lead
);

   logic [19:0]          sp;
   logic signed [MAG_BITS:0] pos;
   logic signed [MAG_BITS:0] offx;
   logic signed [MAG_BITS:0] diff;
   logic [MAG_BITS-1:0]  mag_in;

   logic                 valid_ff [MAG_BITS+1];
   logic                 neg_ff   [MAG_BITS+1];
   logic [MAG_BITS-1:0]  mag_ff   [MAG_BITS+1];
   logic [19:0]          rem_ff   [MAG_BITS+1];
   pix_type              pix_ff   [MAG_BITS+1];

   assign sp     = (cfg.stripe_spacing == 20'd0) ? 20'd1 : cfg.stripe_spacing;
   assign pos    = $signed((MAG_BITS+1)'({in_coord, 8'h00}));
   assign offx   = (MAG_BITS+1)'($signed(cfg.pattern_offset));
   assign diff   = pos - offx;
   assign mag_in = diff[MAG_BITS] ? MAG_BITS'(-diff) : MAG_BITS'(diff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (adv) begin
         valid_ff[0] <= in_valid;
      end
      if (adv) begin
         neg_ff[0] <= diff[MAG_BITS];
         mag_ff[0] <= mag_in;
         rem_ff[0] <= 20'd0;
         pix_ff[0] <= in_pix;
      end
   end

   // one quotient bit per stage, remainder only
   for (genvar i = 0; i < MAG_BITS; i++) begin : g_mod
      logic [20:0] trial;
      logic [19:0] rem_in;
      assign trial  = {rem_ff[i], mag_ff[i][MAG_BITS-1-i]};
      assign rem_in = (trial >= {1'b0, sp}) ? 20'(trial - {1'b0, sp}) : trial[19:0];
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i+1] <= 1'b0;
         end else if (adv) begin
            valid_ff[i+1] <= valid_ff[i];
         end
         if (adv) begin
            neg_ff[i+1] <= neg_ff[i];
            mag_ff[i+1] <= mag_ff[i];
            rem_ff[i+1] <= rem_in;
            pix_ff[i+1] <= pix_ff[i];
         end
      end
   end

   logic [19:0] rem_last;
   logic [19:0] r_in;
   logic [20:0] pp;
   logic [20:0] spx;
   logic        valid_o_ff;
   pix_type     pix_o_ff;
   logic [20:0] d2_ff;
   logic        lead_ff;

   assign rem_last = rem_ff[MAG_BITS];
   assign r_in     = (neg_ff[MAG_BITS] && (rem_last != 20'd0)) ? (sp - rem_last) : rem_last;
   assign pp       = {r_in, 1'b0};
   assign spx      = {1'b0, sp};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_o_ff <= 1'b0;
      end else if (adv) begin
         valid_o_ff <= valid_ff[MAG_BITS];
      end
      if (adv) begin
         pix_o_ff <= pix_ff[MAG_BITS];
         d2_ff    <= (pp >= spx) ? (pp - spx) : (spx - pp);
         lead_ff  <= (pp < spx);
      end
   end

   assign out_valid = valid_o_ff;
   assign out_pix   = pix_o_ff;
   assign out_d2    = d2_ff;
   assign out_lead  = lead_ff;

endmodule

>>> hw/rtl/smpb_falloff.sv
`timescale 1ns / 1ps
module smpb_falloff import smpb_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  cfg_type              cfg,
   input  logic                 in_valid,
   input  pix_type              in_pix,
   input  logic [20:0]          in_d2,
   input  logic                 in_lead,
   output logic                 out_valid,
   output pix_type              out_pix,
   output logic [MASK_BITS-1:0] out_mask
);

   logic [15:0]          fmax;
   logic [15:0]          fs;
   logic [21:0]          limit;
   logic [20:0]          edge_w;
   logic [EDGE_BITS-1:0] edge2;
   logic [DIV_BITS-1:0]  div_in;
   logic [NUM_BITS-1:0]  num_in;
   logic                 full_in;
   logic                 zero_in;

   assign fmax    = (cfg.feather_lead > cfg.feather_trail) ? cfg.feather_lead : cfg.feather_trail;
   assign fs      = in_lead ? cfg.feather_lead : cfg.feather_trail;
   assign limit   = 22'(cfg.stripe_width) + {5'd0, fmax, 1'b0};
   assign edge_w  = in_d2 - {1'b0, cfg.stripe_width};
   assign edge2   = edge_w[EDGE_BITS-1:0];
   assign div_in  = {fs, 2'b00};
   assign num_in  = NUM_BITS'(edge2) * NUM_BITS'(FALLOFF_TABLE_DEPTH);
   assign full_in = ({1'b0, in_d2} <= 22'(cfg.stripe_width));
   // beyond the outer edge, no feather on this side, or past the table
   assign zero_in = ({1'b0, in_d2} > limit) || (fs == 16'd0)
                    || (18'(edge2) >= div_in);

   logic                  valid_ff [IDX_BITS+1];
   pix_type               pix_ff   [IDX_BITS+1];
   logic                  full_ff  [IDX_BITS+1];
   logic                  zero_ff  [IDX_BITS+1];
   logic [NUM_BITS-1:0]   num_ff   [IDX_BITS+1];
   logic [DIV_BITS-1:0]   div_ff   [IDX_BITS+1];
   logic [DIV_BITS:0]     rem_ff   [IDX_BITS+1];
   logic [IDX_BITS-1:0]   q_ff     [IDX_BITS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (adv) begin
         valid_ff[0] <= in_valid;
      end
      if (adv) begin
         pix_ff[0]  <= in_pix;
         full_ff[0] <= full_in;
         zero_ff[0] <= zero_in;
         num_ff[0]  <= num_in;
         div_ff[0]  <= div_in;
         rem_ff[0]  <= (DIV_BITS+1)'(num_in >> IDX_BITS);
         q_ff[0]    <= '0;
      end
   end

   for (genvar j = 0; j < IDX_BITS; j++) begin : g_div
      logic [DIV_BITS+1:0] trial;
      logic                take;
      logic [DIV_BITS:0]   rem_in;
      assign trial  = {rem_ff[j], num_ff[j][IDX_BITS-1-j]};
      assign take   = (trial >= (DIV_BITS+2)'(div_ff[j]));
      assign rem_in = take ? (DIV_BITS+1)'(trial - (DIV_BITS+2)'(div_ff[j]))
                           : trial[DIV_BITS:0];
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j+1] <= 1'b0;
         end else if (adv) begin
            valid_ff[j+1] <= valid_ff[j];
         end
         if (adv) begin
            pix_ff[j+1]  <= pix_ff[j];
            full_ff[j+1] <= full_ff[j];
            zero_ff[j+1] <= zero_ff[j];
            num_ff[j+1]  <= num_ff[j];
            div_ff[j+1]  <= div_ff[j];
            rem_ff[j+1]  <= rem_in;
            q_ff[j+1]    <= {q_ff[j][IDX_BITS-2:0], take};
         end
      end
   end

   logic [IDX_BITS-1:0]  k;
   logic [MASK_BITS-1:0] rom_val;
   logic [MASK_BITS-1:0] mask_in;
   logic                 valid_o_ff;
   pix_type              pix_o_ff;
   logic [MASK_BITS-1:0] mask_ff;

   assign k       = q_ff[IDX_BITS];
   assign rom_val = (32'(k) < 32'(FALLOFF_TABLE_DEPTH)) ? FALLOFF_ROM[k] : '0;
   assign mask_in = full_ff[IDX_BITS] ? MASK_FULL :
                    (zero_ff[IDX_BITS] ? '0 : rom_val);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_o_ff <= 1'b0;
      end else if (adv) begin
         valid_o_ff <= valid_ff[IDX_BITS];
      end
      if (adv) begin
         pix_o_ff <= pix_ff[IDX_BITS];
         mask_ff  <= mask_in;
      end
   end

   assign out_valid = valid_o_ff;
   assign out_pix   = pix_o_ff;
   assign out_mask  = mask_ff;

endmodule

>>> hw/rtl/smpb_gain.sv
`timescale 1ns / 1ps
module smpb_gain import smpb_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  cfg_type              cfg,
   input  logic                 in_valid,
   input  pix_type              in_pix,
   input  logic [MASK_BITS-1:0] in_mask,
   output logic                 out_valid,
   output rsp_type              out_rsp
);

   // scale by opacity
   logic [33:0] mo;
   logic        v0_ff;
   pix_type     pix0_ff;
   logic [17:0] m_ff;

   assign mo = 34'(in_mask) * 34'(cfg.effect_opacity);

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (adv) begin
         v0_ff <= in_valid;
      end
      if (adv) begin
         pix0_ff <= in_pix;
         m_ff    <= mo[33:16];
      end
   end

   // channel products
   logic [18:0] gain;
   logic        v1_ff;
   logic [19:0] alpha1_ff;
   logic [38:0] pr_ff;
   logic [38:0] pg_ff;
   logic [38:0] pb_ff;

   assign gain = 19'd131072 + 19'(m_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= v0_ff;
      end
      if (adv) begin
         alpha1_ff <= pix0_ff.alpha;
         pr_ff     <= 39'(pix0_ff.red) * 39'(gain);
         pg_ff     <= 39'(pix0_ff.green) * 39'(gain);
         pb_ff     <= 39'(pix0_ff.blue) * 39'(gain);
      end
   end

   // saturate into the output register
   function automatic logic [19:0] sat(input logic [38:0] p);
      logic [21:0] v;
      v = p[38:17];
      return (v[21:20] != 2'b00) ? 20'hFFFFF : v[19:0];
   endfunction

   logic    v2_ff;
   rsp_type rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
      end
      if (adv) begin
         rsp_ff.red_out   <= sat(pr_ff);
         rsp_ff.green_out <= sat(pg_ff);
         rsp_ff.blue_out  <= sat(pb_ff);
         rsp_ff.alpha_out <= alpha1_ff;
      end
   end

   assign out_valid = v2_ff;
   assign out_rsp   = rsp_ff;

endmodule

>>> hw/rtl/stripe_mask_pixel_boost_core.sv
`timescale 1ns / 1ps
// stripe mask pixel boost: one pixel transaction enters per cycle unless the
// pipeline is stalled. the pipeline is made of the wrap stage, which reduces
// the shifted position modulo the stripe spacing one bit per stage (25 stages
// with the default 16-bit coordinates), the falloff divider, one table index
// bit per stage (8 stages with the 256-entry falloff table), and the opacity
// and channel multipliers. the whole pipeline holds while a result waits on
// rsp_stall, so req_stall follows rsp_stall whenever the output register is
// full. the user must write registers through the csr port only while no
// transaction is in flight; the block itself does not enforce this.
module stripe_mask_pixel_boost_core import smpb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // request transactions
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   // response transactions
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   // register writes
   input  logic        csr_write_en,
   input  logic [2:0]  csr_index,
   input  logic [20:0] csr_wdata
);

   // configuration registers
   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_idx_type'(csr_index))
            CSR_SPACING:   cfg_in.stripe_spacing   = csr_wdata[19:0];
            CSR_WIDTH:     cfg_in.stripe_width     = csr_wdata[19:0];
            CSR_LEAD:      cfg_in.feather_lead     = csr_wdata[15:0];
            CSR_TRAIL:     cfg_in.feather_trail    = csr_wdata[15:0];
            CSR_OFFSET:    cfg_in.pattern_offset   = csr_wdata[20:0];
            CSR_OPACITY:   cfg_in.effect_opacity   = csr_wdata[16:0];
            CSR_DIRECTION: cfg_in.stripe_direction = csr_wdata[0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stripe_spacing   <= 20'd31488;
         cfg_ff.stripe_width     <= 20'd4096;
         cfg_ff.feather_lead     <= 16'd512;
         cfg_ff.feather_trail    <= 16'd512;
         cfg_ff.pattern_offset   <= 21'd0;
         cfg_ff.effect_opacity   <= 17'd65536;
         cfg_ff.stripe_direction <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // global advance: everything moves unless a finished result is held
   logic adv;
   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   // pick the coordinate along the stripe direction
   logic [15:0]           coord_sel;
   logic [COORD_BITS-1:0] coord;
   pix_type               pix_in;

   assign coord_sel = cfg_ff.stripe_direction ? req_data.row : req_data.column;
   assign coord     = COORD_BITS'(coord_sel);
   assign pix_in    = '{red:   req_data.red_in,
                        green: req_data.green_in,
                        blue:  req_data.blue_in,
                        alpha: req_data.alpha_in};

   // position within the period, distance from its middle (doubled)
   logic        w_valid;
   pix_type     w_pix;
   logic [20:0] w_d2;
   logic        w_lead;

   smpb_wrap u_wrap (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .cfg       (cfg_ff),
      .in_valid  (req_valid),
      .in_coord  (coord),
      .in_pix    (pix_in),
      .out_valid (w_valid),
      .out_pix   (w_pix),
      .out_d2    (w_d2),
      .out_lead  (w_lead)
   );

   // core / feather / outside classification and gaussian lookup
   logic                 f_valid;
   pix_type              f_pix;
   logic [MASK_BITS-1:0] f_mask;

   smpb_falloff u_falloff (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .cfg       (cfg_ff),
      .in_valid  (w_valid),
      .in_pix    (w_pix),
      .in_d2     (w_d2),
      .in_lead   (w_lead),
      .out_valid (f_valid),
      .out_pix   (f_pix),
      .out_mask  (f_mask)
   );

   // opacity, channel gain and saturation; last stage is the output register
   smpb_gain u_gain (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .cfg       (cfg_ff),
      .in_valid  (f_valid),
      .in_pix    (f_pix),
      .in_mask   (f_mask),
      .out_valid (rsp_valid),
      .out_rsp   (rsp_data)
   );

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
   import smpb_pkg::*;

   localparam int LATENCY = 40;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        csr_write_en;
   logic [2:0]  csr_index;
   logic [20:0] csr_wdata;

   stripe_mask_pixel_boost_core i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // predictor copy of the register file and the falloff table
   logic [19:0] spacing_r, width_r;
   logic [15:0] lead_r, trail_r;
   logic [20:0] offset_r;
   logic [16:0] opacity_r;
   logic        direction_r;
   logic [16:0] falloff_tbl [FALLOFF_TABLE_DEPTH];

   req_type pixel_queue [$];
   rsp_type boosted_queue [$];
   int      errors;
   bit      idle_enable;
   bit      hold_request;
   int      hold_count;
   bit      req_taken;

   initial begin
      clock = 1'b0;
   end
   always #10 clock = ~clock;

   initial begin
      #500ms;
      $display("Simulation FAILED");
      $finish;
   end

   // exp(-f) in q30 by taylor series
   function automatic longint unsigned neg_exp_q30(input longint unsigned f);
      longint          acc;
      longint unsigned term;
      acc  = longint'(64'd1 << 30);
      term = 64'd1 << 30;
      for (int i = 1; i <= 14; i++) begin
         term = ((term * f) >> 30) / longint'(i);
         if (i % 2 == 1) begin
            acc = acc - longint'(term);
         end else begin
            acc = acc + longint'(term);
         end
      end
      return (acc < 0) ? 0 : longint'(acc);
   endfunction

   task automatic fill_falloff();
      longint unsigned e1, e, n, v;
      e1 = neg_exp_q30(64'd1 << 30);
      for (int k = 0; k < FALLOFF_TABLE_DEPTH; k++) begin
         e = ((64'd25 * k * k) << 29) / (FALLOFF_TABLE_DEPTH * FALLOFF_TABLE_DEPTH);
         n = e >> 30;
         v = neg_exp_q30(e & ((64'd1 << 30) - 1));
         for (longint unsigned j = 0; j < n; j++) v = (v * e1) >> 30;
         falloff_tbl[k] = 17'((v + 8192) >> 14);
      end
   endtask

   // mask strength for one coordinate, 65536 = full
   function automatic longint unsigned stripe_strength(input longint unsigned coord);
      longint          sp, off, pos, r;
      longint unsigned pp, d2, fmax, fs, k;
      sp  = (spacing_r == 0) ? 1 : longint'(spacing_r);
      off = longint'($signed(offset_r));
      pos = longint'(coord << 8) - off;
      r   = pos % sp;
      if (r < 0) r = r + sp;
      pp = r * 2;
      d2 = (pp >= sp) ? pp - sp : sp - pp;
      fmax = (lead_r > trail_r) ? lead_r : trail_r;
      if (d2 > width_r + 2 * fmax) return 0;
      if (d2 <= width_r) return 65536;
      fs = (pp < sp) ? lead_r : trail_r;
      if (fs == 0) return 0;
      k = ((d2 - width_r) * FALLOFF_TABLE_DEPTH) / (4 * fs);
      if (k >= FALLOFF_TABLE_DEPTH) return 0;
      return falloff_tbl[k];
   endfunction

   function automatic rsp_type boost_pixel(input req_type px);
      rsp_type         res;
      longint unsigned coord, gain, v [3];
      coord = (direction_r ? px.row : px.column) & ((64'd1 << COORD_BITS) - 1);
      gain  = 131072 + ((stripe_strength(coord) * opacity_r) >> 16);
      v[0] = (px.red_in * gain) >> 17;
      v[1] = (px.green_in * gain) >> 17;
      v[2] = (px.blue_in * gain) >> 17;
      res.red_out   = (v[0] > 20'hFFFFF) ? 20'hFFFFF : 20'(v[0]);
      res.green_out = (v[1] > 20'hFFFFF) ? 20'hFFFFF : 20'(v[1]);
      res.blue_out  = (v[2] > 20'hFFFFF) ? 20'hFFFFF : 20'(v[2]);
      res.alpha_out = px.alpha_in;
      return res;
   endfunction

   // remember whether the offered transaction went in at the last rising edge
   always @(posedge clock) begin
      req_taken <= req_valid && !req_stall;
   end

   // driver: next pixel transaction and receiver stall at the falling edge
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || req_taken) begin
            if (pixel_queue.size() > 0 && !(idle_enable && $urandom_range(99) < 34)) begin
               req_data  <= pixel_queue.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
         if (hold_count > 0) begin
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= idle_enable && ($urandom_range(99) < 34);
         end
      end
   end

   // long receiver hold-off so the pipeline fills and stalls its input
   always @(posedge clock) begin
      if (hold_request && hold_count == 0) begin
         hold_count <= 120;
      end else if (hold_count > 0) begin
         hold_count <= hold_count - 1;
      end
   end

   // monitor: accepted pixel goes into the prediction, accepted result is checked
   always @(posedge clock) begin
      rsp_type expd;
      if (!reset) begin
         if (req_valid && !req_stall) boosted_queue.push_back(boost_pixel(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (boosted_queue.size() == 0) begin
               $display("%0t unexpected result, expected none, actual %h", $time, rsp_data);
               errors++;
            end else begin
               expd = boosted_queue.pop_front();
               if (expd.red_out !== rsp_data.red_out ||
                   expd.green_out !== rsp_data.green_out ||
                   expd.blue_out !== rsp_data.blue_out ||
                   expd.alpha_out !== rsp_data.alpha_out) begin
                  $display("%0t mismatch expected %h %h %h %h actual %h %h %h %h", $time,
                     expd.red_out, expd.green_out, expd.blue_out, expd.alpha_out,
                     rsp_data.red_out, rsp_data.green_out, rsp_data.blue_out,
                     rsp_data.alpha_out);
                  errors++;
               end
            end
         end
      end
   end

   task automatic write_reg(input csr_idx_type idx, input logic [20:0] value);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      @(negedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         CSR_SPACING:   spacing_r   = value[19:0];
         CSR_WIDTH:     width_r     = value[19:0];
         CSR_LEAD:      lead_r      = value[15:0];
         CSR_TRAIL:     trail_r     = value[15:0];
         CSR_OFFSET:    offset_r    = value;
         CSR_OPACITY:   opacity_r   = value[16:0];
         CSR_DIRECTION: direction_r = value[0];
         default: ;
      endcase
   endtask

   task automatic drain();
      int guard;
      guard = 0;
      while ((pixel_queue.size() > 0 || req_valid || boosted_queue.size() > 0)
             && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      if (guard >= 200000) begin
         $display("Simulation FAILED");
         $finish;
      end
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   function automatic req_type random_pixel(input bit wide);
      req_type px;
      px.column   = wide ? 16'($urandom) : 16'($urandom_range(300));
      px.row      = wide ? 16'($urandom) : 16'($urandom_range(300));
      px.red_in   = 20'($urandom);
      px.green_in = 20'($urandom);
      px.blue_in  = 20'($urandom);
      px.alpha_in = 20'($urandom);
      if ($urandom_range(9) == 0) px.red_in = 20'hFFFFF;
      if ($urandom_range(9) == 0) px.green_in = 20'h0;
      return px;
   endfunction

   task automatic random_phase(input int count);
      for (int i = 0; i < count; i++) pixel_queue.push_back(random_pixel($urandom_range(3) == 0));
      drain();
   endtask

   initial begin
      req_type px;
      errors       = 0;
      idle_enable  = 1'b0;
      hold_request = 1'b0;
      hold_count   = 0;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      rsp_stall    = 1'b0;
      csr_write_en = 1'b0;
      csr_index    = CSR_SPACING;
      csr_wdata    = '0;
      spacing_r = 31488; width_r = 4096; lead_r = 512; trail_r = 512;
      offset_r = 0; opacity_r = 65536; direction_r = 0;
      fill_falloff();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: sweep columns across one period at reset settings, channel extremes
      for (int i = 0; i < 16; i++) begin
         px = '0;
         px.column   = 16'(i * 8);
         px.row      = 16'hFFFF;
         px.red_in   = (i % 2) ? 20'hFFFFF : 20'h10000;
         px.green_in = 20'(i * 4096);
         px.blue_in  = (i % 3 == 0) ? 20'h0 : 20'hABCDE;
         px.alpha_in = (i % 2) ? 20'hFFFFF : 20'h0;
         pixel_queue.push_back(px);
      end
      px = '0; px.column = 16'hFFFF; px.red_in = 20'hFFFFF; px.green_in = 20'hFFFFF;
      px.blue_in = 20'hFFFFF; px.alpha_in = 20'h5A5A5;
      pixel_queue.push_back(px);
      drain();

      // zero spacing, zero feathers, opacity above full, row direction
      write_reg(CSR_SPACING, 21'd0);
      write_reg(CSR_LEAD, 21'd0);
      write_reg(CSR_TRAIL, 21'd0);
      write_reg(CSR_OPACITY, 21'h1FFFF);
      write_reg(CSR_DIRECTION, 21'd1);
      random_phase(8);
      write_reg(CSR_SPACING, 21'd2000);
      write_reg(CSR_WIDTH, 21'd100);
      random_phase(8);

      idle_enable = 1'b1;
      // several settings: extremes, feathered edges, negative offset
      for (int ph = 0; ph < 9; ph++) begin
         case (ph)
            0: begin
               write_reg(CSR_SPACING, 21'hFFFFF); write_reg(CSR_WIDTH, 21'hFFFFF);
               write_reg(CSR_LEAD, 21'hFFFF); write_reg(CSR_TRAIL, 21'hFFFF);
               write_reg(CSR_OFFSET, 21'h0FFFFF); write_reg(CSR_OPACITY, 21'd0);
               write_reg(CSR_DIRECTION, 21'd0);
            end
            1: begin
               write_reg(CSR_SPACING, 21'd256); write_reg(CSR_WIDTH, 21'd0);
               write_reg(CSR_LEAD, 21'd40); write_reg(CSR_TRAIL, 21'd90);
               write_reg(CSR_OFFSET, 21'h100000); write_reg(CSR_OPACITY, 21'd65536);
            end
            2: begin
               write_reg(CSR_SPACING, 21'd7777); write_reg(CSR_WIDTH, 21'd1000);
               write_reg(CSR_LEAD, 21'd1500); write_reg(CSR_TRAIL, 21'd0);
               write_reg(CSR_OFFSET, 21'h1FFF00); write_reg(CSR_DIRECTION, 21'd1);
            end
            default: begin
               write_reg(CSR_SPACING, 21'($urandom_range(40000, 256)));
               write_reg(CSR_WIDTH, 21'($urandom_range(8000)));
               write_reg(CSR_LEAD, 21'($urandom_range(5000)));
               write_reg(CSR_TRAIL, 21'($urandom_range(5000)));
               write_reg(CSR_OFFSET, 21'($urandom));
               write_reg(CSR_OPACITY, 21'($urandom_range(65536)));
               write_reg(CSR_DIRECTION, 21'($urandom_range(1)));
            end
         endcase
         if (ph == 4) begin
            // no idling for a stretch, then a long receiver hold-off
            idle_enable = 1'b0;
            for (int i = 0; i < 100; i++) pixel_queue.push_back(random_pixel(0));
            hold_request = 1'b1;
            @(negedge clock);
            hold_request = 1'b0;
            drain();
            idle_enable = 1'b1;
         end else begin
            random_phase(100);
         end
      end

      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
